// ===== sv/swn_pkg.sv =====
package swn_pkg;

   // sizes of the weight map
   localparam int MAX_LAYERS = 8;
   localparam int MAX_WIDTH = 256;
   localparam int MAX_HEIGHT = 256;

   // fixed field widths
   localparam int WEIGHT_W = 8;
   localparam int IN_LAYER_W = 3;
   localparam int POS_W = 11;
   localparam int OUT_XY_W = 8;
   localparam int MAP_DIM_W = 9;
   localparam int LCNT_REG_W = 4;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_INDEX_W = 2;

   localparam int FULL_WEIGHT = 255;
   localparam int EDGE_MARGIN = 2;

   // derived widths
   localparam int LAYER_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int LCNT_W = $clog2(MAX_LAYERS + 1);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int ADDR_W = XW + YW;
   localparam int DEPTH = 2 ** ADDR_W;
   localparam int OTHERS_W = WEIGHT_W + LAYER_W;
   localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int CMP_W = (($clog2(DIM_MAX + 1) > POS_W) ? $clog2(DIM_MAX + 1) : POS_W) + 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAP_WIDTH   = 2'd0,
      CSR_MAP_HEIGHT  = 2'd1,
      CSR_LAYER_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_CHECK,
      BK_SCALE,
      BK_FINAL
   } back_state_type;

   typedef logic [MAX_LAYERS-1:0][WEIGHT_W-1:0] row_type;

   typedef struct packed {
      logic [LAYER_W-1:0]  layer;
      logic [XW-1:0]       x;
      logic [YW-1:0]       y;
      logic [WEIGHT_W-1:0] weight;
      logic [LCNT_W-1:0]   count;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // floor(p / 255) for any p below 65280
   function automatic logic [WEIGHT_W-1:0] div255(input logic [2*WEIGHT_W-1:0] p);
      logic [2*WEIGHT_W:0] s;
      s = (2*WEIGHT_W+1)'(p) + (2*WEIGHT_W+1)'(1) + (2*WEIGHT_W+1)'(p[2*WEIGHT_W-1:WEIGHT_W]);
      return s[2*WEIGHT_W-1:WEIGHT_W];
   endfunction

endpackage

// ===== sv/splat_weight_normalizer.sv =====
// per-pixel, per-layer blend weight map with splat normalization. after reset
// the block runs a clearing pass over all 65536 pixel rows of the map and holds
// busy high throughout it; configuration writes are taken throughout.
// a sample is taken on a clock edge with start high and busy low. the front end
// checks bounds and layer in that cycle; a sample outside the paintable area or
// on a layer not in use is simply consumed with no result. kept samples wait in
// a two-entry queue, so busy rises only while the queue is full or the map is
// being cleared. for a kept sample the back end pops it and issues the row
// read, waits on the read data, compares the stored weight, scales each layer
// in use in turn (the single 8x8 multiplier is shared across layers), and
// writes the remainder back; a sample dropped for a low weight ends after the
// compare. results come out one per cycle at most, each shown on the
// rsp_ ports for exactly one cycle with rsp_strobe high, in layer order with
// the painted layer's final beat last and rsp_last set. there is no way to
// stall results: the receiver must take every beat as it appears
module splat_weight_normalizer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [swn_pkg::IN_LAYER_W-1:0]       req_layer,
   input  logic signed [swn_pkg::POS_W-1:0]     req_pos_x,
   input  logic signed [swn_pkg::POS_W-1:0]     req_pos_y,
   input  logic [swn_pkg::WEIGHT_W-1:0]         req_weight,
   input  logic                                 csr_write_en,
   input  logic [swn_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [swn_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic                                 rsp_strobe,
   output logic [swn_pkg::IN_LAYER_W-1:0]       rsp_out_layer,
   output logic [swn_pkg::OUT_XY_W-1:0]         rsp_out_x,
   output logic [swn_pkg::OUT_XY_W-1:0]         rsp_out_y,
   output logic [swn_pkg::WEIGHT_W-1:0]         rsp_out_weight,
   output logic                                 rsp_last
);

   logic                       push;
   swn_pkg::item_type          push_item;
   logic                       pop;
   swn_pkg::item_type          pop_item;
   swn_pkg::queue_status_type  q_status;
   logic                       clearing;

   // hold off new samples while the map is cleared or the queue is full
   assign busy = clearing || q_status.full;

   // front end: config registers, bounds and layer checks
   swn_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_layer    (req_layer),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_weight   (req_weight),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .push         (push),
      .push_item    (push_item)
   );

   // decouples sample intake from the per-layer work
   swn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   // back end: map memory, read-modify-write and result beats
   swn_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_item         (pop_item),
      .q_pop          (pop),
      .clearing       (clearing),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_layer  (rsp_out_layer),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_weight (rsp_out_weight),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== sv/swn_front.sv =====
module swn_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [swn_pkg::IN_LAYER_W-1:0]       req_layer,
   input  logic signed [swn_pkg::POS_W-1:0]     req_pos_x,
   input  logic signed [swn_pkg::POS_W-1:0]     req_pos_y,
   input  logic [swn_pkg::WEIGHT_W-1:0]         req_weight,
   input  logic                                 csr_write_en,
   input  logic [swn_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [swn_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic                                 push,
   output swn_pkg::item_type                    push_item
);

   logic [swn_pkg::MAP_DIM_W-1:0]  map_width_ff;
   logic [swn_pkg::MAP_DIM_W-1:0]  map_height_ff;
   logic [swn_pkg::LCNT_REG_W-1:0] layer_count_ff;

   logic [swn_pkg::CMP_W-1:0]        wd_eff, ht_eff;
   logic signed [swn_pkg::CMP_W-1:0] x_s, y_s, x_lim, y_lim;
   logic [swn_pkg::LCNT_W-1:0]       count_eff;
   logic                             x_ok, y_ok, layer_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff   <= swn_pkg::MAP_DIM_W'(256);
         map_height_ff  <= swn_pkg::MAP_DIM_W'(256);
         layer_count_ff <= swn_pkg::LCNT_REG_W'(1);
      end else if (csr_write_en) begin
         case (csr_index)
            swn_pkg::CSR_MAP_WIDTH: begin
               map_width_ff <= csr_data[swn_pkg::MAP_DIM_W-1:0];
            end
            swn_pkg::CSR_MAP_HEIGHT: begin
               map_height_ff <= csr_data[swn_pkg::MAP_DIM_W-1:0];
            end
            swn_pkg::CSR_LAYER_COUNT: begin
               layer_count_ff <= csr_data[swn_pkg::LCNT_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      // clamp map size to the stored area
      wd_eff = (swn_pkg::CMP_W'(map_width_ff) > swn_pkg::CMP_W'(swn_pkg::MAX_WIDTH))
               ? swn_pkg::CMP_W'(swn_pkg::MAX_WIDTH) : swn_pkg::CMP_W'(map_width_ff);
      ht_eff = (swn_pkg::CMP_W'(map_height_ff) > swn_pkg::CMP_W'(swn_pkg::MAX_HEIGHT))
               ? swn_pkg::CMP_W'(swn_pkg::MAX_HEIGHT) : swn_pkg::CMP_W'(map_height_ff);
      x_lim = signed'(wd_eff - swn_pkg::CMP_W'(swn_pkg::EDGE_MARGIN));
      y_lim = signed'(ht_eff - swn_pkg::CMP_W'(swn_pkg::EDGE_MARGIN));
      x_s = swn_pkg::CMP_W'(req_pos_x);
      y_s = swn_pkg::CMP_W'(req_pos_y);
      x_ok = !x_s[swn_pkg::CMP_W-1] && (x_s < x_lim);
      y_ok = !y_s[swn_pkg::CMP_W-1] && (y_s < y_lim);

      count_eff = ((swn_pkg::LCNT_W + swn_pkg::LCNT_REG_W)'(layer_count_ff) >
                   (swn_pkg::LCNT_W + swn_pkg::LCNT_REG_W)'(swn_pkg::MAX_LAYERS))
                  ? swn_pkg::LCNT_W'(swn_pkg::MAX_LAYERS) : swn_pkg::LCNT_W'(layer_count_ff);
      layer_ok = (count_eff != '0) &&
                 ((swn_pkg::LCNT_W + swn_pkg::IN_LAYER_W)'(req_layer) <
                  (swn_pkg::LCNT_W + swn_pkg::IN_LAYER_W)'(count_eff));

      push = start && !busy && x_ok && y_ok && layer_ok;

      push_item.layer  = swn_pkg::LAYER_W'(req_layer);
      push_item.x      = swn_pkg::XW'(x_s);
      push_item.y      = swn_pkg::YW'(y_s);
      push_item.weight = req_weight;
      push_item.count  = count_eff;
   end

endmodule

// ===== sv/swn_queue.sv =====
module swn_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  swn_pkg::item_type          push_item,
   input  logic                       pop,
   output swn_pkg::item_type          pop_item,
   output swn_pkg::queue_status_type  status
);

   swn_pkg::item_type            entry_ff [swn_pkg::QUEUE_DEPTH];
   logic [swn_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [swn_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [swn_pkg::QPTR_W:0]     fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + swn_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + swn_pkg::QPTR_W'(1) : rd_ptr_ff;
      fill_in = fill_ff + (swn_pkg::QPTR_W+1)'(push) - (swn_pkg::QPTR_W+1)'(pop);
      status.full = (fill_ff == (swn_pkg::QPTR_W+1)'(swn_pkg::QUEUE_DEPTH));
      status.empty = (fill_ff == '0);
      pop_item = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/swn_back.sv =====
module swn_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swn_pkg::queue_status_type            q_status,
   input  swn_pkg::item_type                    q_item,
   output logic                                 q_pop,
   output logic                                 clearing,
   output logic                                 rsp_strobe,
   output logic [swn_pkg::IN_LAYER_W-1:0]       rsp_out_layer,
   output logic [swn_pkg::OUT_XY_W-1:0]         rsp_out_x,
   output logic [swn_pkg::OUT_XY_W-1:0]         rsp_out_y,
   output logic [swn_pkg::WEIGHT_W-1:0]         rsp_out_weight,
   output logic                                 rsp_last
);

   swn_pkg::row_type weight_mem [swn_pkg::DEPTH];
   swn_pkg::row_type mem_q_ff;

   swn_pkg::back_state_type state_ff, state_in;

   swn_pkg::item_type                cur_ff, cur_in;
   swn_pkg::row_type                 row_ff, row_in;
   logic [swn_pkg::ADDR_W-1:0]       clr_ff, clr_in;
   logic [swn_pkg::LAYER_W-1:0]      k_ff, k_in;
   logic [swn_pkg::OTHERS_W-1:0]     others_ff, others_in;
   logic [swn_pkg::WEIGHT_W-1:0]     scale_ff, scale_in;

   logic                             strobe_ff, strobe_in;
   logic [swn_pkg::IN_LAYER_W-1:0]   out_layer_ff, out_layer_in;
   logic [swn_pkg::OUT_XY_W-1:0]     out_x_ff, out_x_in;
   logic [swn_pkg::OUT_XY_W-1:0]     out_y_ff, out_y_in;
   logic [swn_pkg::WEIGHT_W-1:0]     out_weight_ff, out_weight_in;
   logic                             out_last_ff, out_last_in;

   logic                             mem_we, mem_re;
   logic [swn_pkg::ADDR_W-1:0]       mem_waddr, mem_raddr;
   swn_pkg::row_type                 mem_wdata;

   logic [swn_pkg::WEIGHT_W-1:0]     old_w, new_w, fin_w;
   logic [2*swn_pkg::WEIGHT_W-1:0]   prod;
   logic [swn_pkg::OTHERS_W:0]       diff;
   logic                             last_layer;

   // datapath for one layer step and the final remainder
   always_comb begin
      old_w = row_ff[k_ff];
      prod = (2*swn_pkg::WEIGHT_W)'(scale_ff) * (2*swn_pkg::WEIGHT_W)'(old_w);
      new_w = swn_pkg::div255(prod);
      diff = (swn_pkg::OTHERS_W+1)'(swn_pkg::FULL_WEIGHT) - (swn_pkg::OTHERS_W+1)'(others_ff);
      fin_w = diff[swn_pkg::OTHERS_W] ? '0 : swn_pkg::WEIGHT_W'(diff);
      last_layer = ((swn_pkg::LCNT_W'(k_ff) + swn_pkg::LCNT_W'(1)) == cur_ff.count);
   end

   // next state
   always_comb begin
      case (state_ff)
         swn_pkg::BK_CLEAR: begin
            state_in = (clr_ff == '1) ? swn_pkg::BK_IDLE : swn_pkg::BK_CLEAR;
         end
         swn_pkg::BK_IDLE: begin
            state_in = q_status.empty ? swn_pkg::BK_IDLE : swn_pkg::BK_READ;
         end
         swn_pkg::BK_READ: begin
            state_in = swn_pkg::BK_CHECK;
         end
         swn_pkg::BK_CHECK: begin
            state_in = (cur_ff.weight < mem_q_ff[cur_ff.layer]) ? swn_pkg::BK_IDLE
                                                                : swn_pkg::BK_SCALE;
         end
         swn_pkg::BK_SCALE: begin
            state_in = last_layer ? swn_pkg::BK_FINAL : swn_pkg::BK_SCALE;
         end
         swn_pkg::BK_FINAL: begin
            state_in = swn_pkg::BK_IDLE;
         end
         default: begin
            state_in = swn_pkg::BK_IDLE;
         end
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      cur_in = cur_ff;
      row_in = row_ff;
      clr_in = clr_ff;
      k_in = k_ff;
      others_in = others_ff;
      scale_in = scale_ff;
      strobe_in = 1'b0;
      out_layer_in = out_layer_ff;
      out_x_in = swn_pkg::OUT_XY_W'(cur_ff.x);
      out_y_in = swn_pkg::OUT_XY_W'(cur_ff.y);
      out_weight_in = out_weight_ff;
      out_last_in = 1'b0;
      q_pop = 1'b0;
      mem_re = 1'b0;
      mem_we = 1'b0;
      mem_raddr = {q_item.y, q_item.x};
      mem_waddr = {cur_ff.y, cur_ff.x};
      mem_wdata = row_ff;
      case (state_ff)
         swn_pkg::BK_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in = clr_ff + swn_pkg::ADDR_W'(1);
         end
         swn_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop = 1'b1;
               mem_re = 1'b1;
               cur_in = q_item;
            end
         end
         swn_pkg::BK_CHECK: begin
            row_in = mem_q_ff;
            k_in = '0;
            others_in = '0;
            scale_in = swn_pkg::WEIGHT_W'(swn_pkg::FULL_WEIGHT) - cur_ff.weight;
         end
         swn_pkg::BK_SCALE: begin
            row_in[k_ff] = new_w;
            k_in = k_ff + swn_pkg::LAYER_W'(1);
            if (k_ff != cur_ff.layer) begin
               others_in = others_ff + swn_pkg::OTHERS_W'(new_w);
            end
            if (old_w != '0) begin
               strobe_in = 1'b1;
               out_layer_in = swn_pkg::IN_LAYER_W'(k_ff);
               out_weight_in = new_w;
            end
         end
         swn_pkg::BK_FINAL: begin
            mem_we = 1'b1;
            mem_wdata[cur_ff.layer] = fin_w;
            strobe_in = 1'b1;
            out_layer_in = swn_pkg::IN_LAYER_W'(cur_ff.layer);
            out_weight_in = fin_w;
            out_last_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swn_pkg::BK_CLEAR;
         clr_ff <= '0;
         k_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         k_ff <= k_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      row_ff <= row_in;
      others_ff <= others_in;
      scale_ff <= scale_in;
      out_layer_ff <= out_layer_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_weight_ff <= out_weight_in;
      out_last_ff <= out_last_in;
   end

   // one row holds every layer of a pixel
   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= weight_mem[mem_raddr];
      end
   end

   assign clearing = (state_ff == swn_pkg::BK_CLEAR);
   assign rsp_strobe = strobe_ff;
   assign rsp_out_layer = out_layer_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;
   assign rsp_out_weight = out_weight_ff;
   assign rsp_last = out_last_ff;

endmodule

// ===== sv/swn_checker.sv =====
module swn_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic [swn_pkg::IN_LAYER_W-1:0]       req_layer,
   input logic signed [swn_pkg::POS_W-1:0]     req_pos_x,
   input logic signed [swn_pkg::POS_W-1:0]     req_pos_y,
   input logic [swn_pkg::WEIGHT_W-1:0]         req_weight,
   input logic                                 csr_write_en,
   input logic [swn_pkg::CSR_INDEX_W-1:0]      csr_index,
   input logic [swn_pkg::CSR_DATA_W-1:0]       csr_data,
   input logic                                 rsp_strobe,
   input logic [swn_pkg::IN_LAYER_W-1:0]       rsp_out_layer,
   input logic [swn_pkg::OUT_XY_W-1:0]         rsp_out_x,
   input logic [swn_pkg::OUT_XY_W-1:0]         rsp_out_y,
   input logic [swn_pkg::WEIGHT_W-1:0]         rsp_out_weight,
   input logic                                 rsp_last
);

   // clearing pass keeps intake closed right after reset
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_last_with_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe)
      else $error("rsp_last without rsp_strobe");

   // a new sample is popped, read and compared before its first beat
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("beat right after a final beat");

   // beats of one sample stay on one pixel
   a_same_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=>
         (!rsp_strobe || (rsp_out_x == $past(rsp_out_x) && rsp_out_y == $past(rsp_out_y))))
      else $error("pixel changed within one sample");

endmodule

bind splat_weight_normalizer swn_checker u_swn_checker (.*);
